@@ src/nnps_pkg.sv @@
package nnps_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MAX_COPIES   = 64;

    localparam int CHAN_W    = 8;
    localparam int PIX_W     = 3 * CHAN_W;
    localparam int SCALE_W   = 22;
    localparam int DIM_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
    localparam int POS_W     = DIM_W + SCALE_W;
    localparam int CEIL_W    = POS_W - FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(MAX_COPIES) + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_REPLAY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pixel_t;

    // one classified input word; row_end and frame_end apply to its final copy
    typedef struct packed {
        logic             pix_valid;
        logic             row_end;
        logic             frame_end;
        logic             replay_next;
        logic             seq_error;
        logic [CNT_W-1:0] count;
        pixel_t           px;
    } cmd_t;

    function automatic logic [CEIL_W-1:0] ceil_q(input logic [POS_W-1:0] v);
        return CEIL_W'(v[POS_W-1:FRAC_BITS]) + CEIL_W'(|v[FRAC_BITS-1:0]);
    endfunction

    function automatic logic [CNT_W-1:0] copies(input logic [CEIL_W-1:0] hi,
                                                input logic [CEIL_W-1:0] lo);
        logic [CEIL_W-1:0] d;
        d = hi - lo;
        return (d > CEIL_W'(MAX_COPIES)) ? CNT_W'(MAX_COPIES) : d[CNT_W-1:0];
    endfunction

endpackage

@@ src/nnps_if.sv @@
interface nnps_in_if;
    import nnps_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;

    modport source(output valid, opcode, blue, green, red, input ready);
    modport sink(input valid, opcode, blue, green, red, output ready);
endinterface

interface nnps_out_if;
    import nnps_pkg::*;

    logic              valid;
    logic              ready;
    logic              pixel_valid;
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              last;
    logic              row_end;
    logic              frame_end;
    logic              replay_next;
    logic              sequence_error;

    modport source(output valid, pixel_valid, out_blue, out_green, out_red, last,
                   row_end, frame_end, replay_next, sequence_error, input ready);
    modport sink(input valid, pixel_valid, out_blue, out_green, out_red, last,
                 row_end, frame_end, replay_next, sequence_error, output ready);
endinterface

@@ src/nnps_front.sv @@
module nnps_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [nnps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nnps_pkg::SCALE_W-1:0]   cfg_data,
    nnps_in_if.sink                        pixels,
    input  logic [nnps_pkg::LEVEL_W-1:0]   level,
    output logic                           push,
    output nnps_pkg::cmd_t                 push_cmd
);
    import nnps_pkg::*;

    typedef enum logic [1:0] {
        PH_RUN,
        PH_DIMS,
        PH_LOAD
    } phase_t;

    phase_t phase_reg;

    logic [SCALE_W-1:0] sf_reg;
    logic [DIM_W-1:0]   width_reg, height_reg;
    logic [DIM_W-1:0]   weff_reg, heff_reg;
    logic [CEIL_W-1:0]  wend_reg, hend_reg;

    logic [COL_W-1:0]   column_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [POS_W-1:0]   x_next_reg, y_next_reg;
    logic [CEIL_W-1:0]  xc_reg, xnc_reg, yc_reg, ync_reg;
    logic [CNT_W-1:0]   rcl_reg;
    logic               replaying_reg;

    logic               b_valid_reg;
    logic               b_tick_reg;
    cmd_t               b_cmd_reg;
    pixel_t             mem_rdata_reg;
    pixel_t             line_store [MAX_WIDTH];

    logic               accept, tick, err, drop;
    logic [CNT_W-1:0]   rc, cc, rcl_dec;
    logic               last_row, rend, final_pass;
    logic               col_wrap, row_wrap, row_done, replaying_next;
    logic [POS_W-1:0]   x_sum, y_sum, sf_pos;
    logic [CEIL_W-1:0]  sf_ceil;
    logic [POS_W-1:0]   wprod, hprod;
    logic [LEVEL_W:0]   in_flight;
    logic               cfg_hit;
    pixel_t             px_in;
    cmd_t               cmd;

    assign in_flight = (LEVEL_W+1)'(level) + (LEVEL_W+1)'(b_valid_reg);
    assign pixels.ready = (phase_reg == PH_RUN) && (in_flight < (LEVEL_W+1)'(QUEUE_DEPTH));
    assign accept = pixels.valid && pixels.ready;
    assign tick   = (pixels.opcode == OP_REPLAY);
    assign err    = (tick != replaying_reg);
    assign px_in  = {pixels.red, pixels.green, pixels.blue};

    assign cfg_hit = (cfg_index == REG_SCALE) || (cfg_index == REG_WIDTH)
                  || (cfg_index == REG_HEIGHT);

    assign sf_pos  = POS_W'(sf_reg);
    assign sf_ceil = ceil_q(sf_pos);
    assign wprod   = weff_reg * sf_reg;
    assign hprod   = heff_reg * sf_reg;

    always_comb
    begin
        rc         = copies(ync_reg, yc_reg);
        cc         = copies(xnc_reg, xc_reg);
        last_row   = (rc != '0) && (ync_reg == hend_reg);
        rend       = (cc != '0) && (xnc_reg == wend_reg);
        final_pass = tick ? (rcl_reg == CNT_W'(1)) : (rc == CNT_W'(1));
        drop       = (!tick && rc == '0) || (cc == '0);
        rcl_dec    = (rcl_reg == '0) ? '0 : rcl_reg - CNT_W'(1);
        col_wrap   = (DIM_W'(column_reg) + DIM_W'(1)) >= weff_reg;
        row_wrap   = (DIM_W'(row_reg) + DIM_W'(1)) >= heff_reg;
        row_done   = col_wrap && (tick ? (rcl_dec == '0) : (rc <= CNT_W'(1)));
        x_sum      = x_next_reg + sf_pos;
        y_sum      = y_next_reg + sf_pos;

        replaying_next = replaying_reg;
        if (col_wrap)
        begin
            replaying_next = tick ? (rcl_dec != '0) : (rc > CNT_W'(1));
        end

        cmd = '0;
        cmd.px    = px_in;
        cmd.count = CNT_W'(1);
        if (err)
        begin
            cmd.seq_error   = 1'b1;
            cmd.replay_next = replaying_reg;
        end
        else if (drop)
        begin
            cmd.replay_next = replaying_next;
        end
        else
        begin
            cmd.pix_valid   = 1'b1;
            cmd.count       = cc;
            cmd.row_end     = rend;
            cmd.frame_end   = rend && final_pass && last_row;
            cmd.replay_next = replaying_next;
        end
    end

    // line store: write on a source pixel of a kept row, read on a replay tick
    always_ff @(posedge clk)
    begin
        if (accept && !err && !tick && rc != '0)
        begin
            line_store[column_reg] <= px_in;
        end
        if (accept && !err && tick)
        begin
            mem_rdata_reg <= line_store[column_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_cmd_reg  <= cmd;
            b_tick_reg <= tick && !err;
        end
    end

    assign push = b_valid_reg;

    always_comb
    begin
        push_cmd = b_cmd_reg;
        if (b_tick_reg)
        begin
            push_cmd.px = mem_rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RUN;
            sf_reg        <= SCALE_W'(1 << FRAC_BITS);
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
            weff_reg      <= DIM_W'(1);
            heff_reg      <= DIM_W'(1);
            wend_reg      <= CEIL_W'(1);
            hend_reg      <= CEIL_W'(1);
            column_reg    <= '0;
            row_reg       <= '0;
            x_next_reg    <= POS_W'(1 << FRAC_BITS);
            y_next_reg    <= POS_W'(1 << FRAC_BITS);
            xc_reg        <= '0;
            yc_reg        <= '0;
            xnc_reg       <= CEIL_W'(1);
            ync_reg       <= CEIL_W'(1);
            rcl_reg       <= '0;
            replaying_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            b_valid_reg <= accept;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SCALE:  sf_reg     <= cfg_data;
                    REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    default:    ;
                endcase
                if (cfg_hit)
                begin
                    phase_reg <= PH_DIMS;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_DIMS:
                    begin
                        // clamp the dimensions into the supported range
                        if (width_reg == '0)
                            weff_reg <= DIM_W'(1);
                        else if (width_reg > DIM_W'(MAX_WIDTH))
                            weff_reg <= DIM_W'(MAX_WIDTH);
                        else
                            weff_reg <= width_reg;
                        if (height_reg == '0)
                            heff_reg <= DIM_W'(1);
                        else if (height_reg > DIM_W'(HEIGHT_LIMIT))
                            heff_reg <= DIM_W'(HEIGHT_LIMIT);
                        else
                            heff_reg <= height_reg;
                        phase_reg <= PH_LOAD;
                    end
                    PH_LOAD:
                    begin
                        wend_reg      <= ceil_q(wprod);
                        hend_reg      <= ceil_q(hprod);
                        column_reg    <= '0;
                        row_reg       <= '0;
                        x_next_reg    <= sf_pos;
                        y_next_reg    <= sf_pos;
                        xc_reg        <= '0;
                        yc_reg        <= '0;
                        xnc_reg       <= sf_ceil;
                        ync_reg       <= sf_ceil;
                        rcl_reg       <= '0;
                        replaying_reg <= 1'b0;
                        phase_reg     <= PH_RUN;
                    end
                    PH_RUN:
                    begin
                        if (accept && !err)
                        begin
                            if (col_wrap)
                            begin
                                column_reg <= '0;
                                x_next_reg <= sf_pos;
                                xc_reg     <= '0;
                                xnc_reg    <= sf_ceil;
                                if (tick)
                                    rcl_reg <= rcl_dec;
                                else if (rc > CNT_W'(1))
                                    rcl_reg <= rc - CNT_W'(1);
                            end
                            else
                            begin
                                column_reg <= column_reg + COL_W'(1);
                                x_next_reg <= x_sum;
                                xc_reg     <= xnc_reg;
                                xnc_reg    <= ceil_q(x_sum);
                            end
                            replaying_reg <= replaying_next;

                            if (row_done)
                            begin
                                if (row_wrap)
                                begin
                                    row_reg    <= '0;
                                    y_next_reg <= sf_pos;
                                    yc_reg     <= '0;
                                    ync_reg    <= sf_ceil;
                                end
                                else
                                begin
                                    row_reg    <= row_reg + ROW_W'(1);
                                    y_next_reg <= y_sum;
                                    yc_reg     <= ync_reg;
                                    ync_reg    <= ceil_q(y_sum);
                                end
                            end
                        end
                    end
                    default: phase_reg <= PH_RUN;
                endcase
            end
        end
    end

endmodule

@@ src/nnps_queue.sv @@
module nnps_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  nnps_pkg::cmd_t               push_cmd,
    input  logic                         pop,
    output logic                         head_valid,
    output nnps_pkg::cmd_t               head_cmd,
    output logic [nnps_pkg::LEVEL_W-1:0] level
);
    import nnps_pkg::*;

    cmd_t              entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic              do_pop;

    assign head_valid = (level_reg != '0);
    assign head_cmd   = entry[rd_ptr_reg];
    assign level      = level_reg;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !do_pop)
                level_reg <= level_reg + LEVEL_W'(1);
            else if (!push && do_pop)
                level_reg <= level_reg - LEVEL_W'(1);
        end
    end

endmodule

@@ src/nnps_back.sv @@
module nnps_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  nnps_pkg::cmd_t head_cmd,
    output logic           pop,
    nnps_out_if.source     results
);
    import nnps_pkg::*;

    logic [CNT_W-1:0]  copy_reg;
    logic              out_valid_reg;
    logic              load, is_last;
    logic [CNT_W-1:0]  copy_inc;

    assign copy_inc = copy_reg + CNT_W'(1);
    assign is_last  = (copy_inc == head_cmd.count);
    assign load     = head_valid && (!out_valid_reg || results.ready);
    assign pop      = load && is_last;

    assign results.valid = out_valid_reg;

    // output word register; pixel fields read zero when no pixel is carried
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            results.pixel_valid    <= head_cmd.pix_valid;
            results.out_blue       <= head_cmd.pix_valid ? head_cmd.px[CHAN_W-1:0] : '0;
            results.out_green      <= head_cmd.pix_valid ? head_cmd.px[2*CHAN_W-1:CHAN_W] : '0;
            results.out_red        <= head_cmd.pix_valid ? head_cmd.px[PIX_W-1:2*CHAN_W] : '0;
            results.last           <= is_last;
            results.row_end        <= head_cmd.row_end && is_last;
            results.frame_end      <= head_cmd.frame_end && is_last;
            results.replay_next    <= head_cmd.replay_next;
            results.sequence_error <= head_cmd.seq_error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            copy_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                copy_reg      <= is_last ? '0 : copy_inc;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ src/nearest_neighbor_pixel_scaler.sv @@
// An accepted input word passes the front buffer register and command queue into the
// output register. Input takes one word per cycle while each word yields one result and
// the output is not stalled; a word with k copies yields k result words, and a 4-entry queue
// lets input run ahead. A register write blocks input during the clamp and load phases.
// Reset: asynchronous, active low; registers return to scale 1.0, 1x1 frame, frame start.
module nearest_neighbor_pixel_scaler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [nnps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nnps_pkg::SCALE_W-1:0]   cfg_data,
    nnps_in_if.sink                        pixels,
    nnps_out_if.source                     results
);
    import nnps_pkg::*;

    logic               push, pop, head_valid;
    cmd_t               push_cmd, head_cmd;
    logic [LEVEL_W-1:0] level;

    nnps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .level     (level),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    nnps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .level      (level)
    );

    nnps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .results    (results)
    );

endmodule

@@ tb/tb_nearest_neighbor_pixel_scaler.sv @@
`timescale 1ns / 1ps

module tb_nearest_neighbor_pixel_scaler;
    import nnps_pkg::*;

    typedef logic [POS_W:0] pos_t;

    typedef struct packed {
        logic              opcode;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_word_t;

    typedef struct packed {
        logic              pixel_valid;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
        logic              last;
        logic              row_end;
        logic              frame_end;
        logic              replay_next;
        logic              sequence_error;
    } pixel_copy_t;

    typedef struct packed {
        logic [DIM_W-1:0] column;
        logic [DIM_W-1:0] row;
        pos_t             x_pos;
        pos_t             y_pos;
        logic [CNT_W-1:0] copies_left;
        logic             replaying;
    } frame_pos_t;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam pos_t ROUND_UP = (pos_t'(1) << FRAC_BITS) - 1;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCALE_W-1:0] cfg_data;

    nnps_in_if  pixels();
    nnps_out_if results();

    nearest_neighbor_pixel_scaler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels),
        .results   (results)
    );

    // shadow registers and frame position of the scaler
    logic [SCALE_W-1:0] cur_scale;
    logic [DIM_W-1:0]   cur_width;
    logic [DIM_W-1:0]   cur_height;
    frame_pos_t         scaler_pos;
    frame_pos_t         plan_pos;
    pixel_t             line_store [MAX_WIDTH];

    pixel_word_t source_words_q [$];
    pixel_copy_t pixel_copies_q [$];
    pixel_word_t driven_word;
    int unsigned sender_idle;
    int unsigned recv_idle;
    int          error_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic pos_t ceil_up(pos_t v);
        return (v + ROUND_UP) >> FRAC_BITS;
    endfunction

    function automatic logic [CNT_W-1:0] copies_at(pos_t p);
        pos_t d;
        d = ceil_up(p + pos_t'(cur_scale)) - ceil_up(p);
        return (d > pos_t'(MAX_COPIES)) ? CNT_W'(MAX_COPIES) : d[CNT_W-1:0];
    endfunction

    function automatic logic [DIM_W-1:0] eff_width();
        if (cur_width == 0)
            return DIM_W'(1);
        if (cur_width > MAX_WIDTH)
            return DIM_W'(MAX_WIDTH);
        return cur_width;
    endfunction

    function automatic logic [DIM_W-1:0] eff_height();
        if (cur_height == 0)
            return DIM_W'(1);
        if (cur_height > HEIGHT_LIMIT)
            return DIM_W'(HEIGHT_LIMIT);
        return cur_height;
    endfunction

    // position after one word of the expected kind
    function automatic frame_pos_t next_pos(frame_pos_t s, logic tick);
        frame_pos_t n;
        logic [CNT_W-1:0] rc;
        n = s;
        rc = copies_at(s.y_pos);
        n.column = s.column + 1'b1;
        n.x_pos = s.x_pos + pos_t'(cur_scale);
        if (n.column >= eff_width())
        begin
            n.column = '0;
            n.x_pos = '0;
            if (!tick && rc > 1)
            begin
                n.replaying = 1'b1;
                n.copies_left = rc - 1'b1;
            end
            else if (tick && s.copies_left > 1)
                n.copies_left = s.copies_left - 1'b1;
            else
            begin
                n.replaying = 1'b0;
                n.copies_left = '0;
                n.row = s.row + 1'b1;
                n.y_pos = s.y_pos + pos_t'(cur_scale);
                if (n.row >= eff_height())
                begin
                    n.row = '0;
                    n.y_pos = '0;
                end
            end
        end
        return n;
    endfunction

    function automatic void predict_copies(pixel_word_t wd);
        logic tick;
        logic err;
        logic valid;
        logic rend;
        logic fend;
        logic last_row;
        logic final_pass;
        logic [CNT_W-1:0] rc;
        logic [CNT_W-1:0] cc;
        pixel_t px;
        frame_pos_t moved;
        pixel_copy_t r;
        int n;
        tick = (wd.opcode == OP_REPLAY);
        err = (tick != scaler_pos.replaying);
        moved = scaler_pos;
        valid = 1'b0;
        rend = 1'b0;
        fend = 1'b0;
        px = '0;
        n = 1;
        if (!err)
        begin
            rc = copies_at(scaler_pos.y_pos);
            last_row = (rc > 0) && (ceil_up(scaler_pos.y_pos + pos_t'(cur_scale)) ==
                        ceil_up(pos_t'(eff_height()) * pos_t'(cur_scale)));
            final_pass = tick ? (scaler_pos.copies_left == 1) : (rc == 1);
            if (tick)
                px = line_store[scaler_pos.column[COL_W-1:0]];
            else
            begin
                px = {wd.red, wd.green, wd.blue};
                if (rc > 0)
                    line_store[scaler_pos.column[COL_W-1:0]] = px;
            end
            cc = copies_at(scaler_pos.x_pos);
            if ((tick || rc != 0) && cc != 0)
            begin
                valid = 1'b1;
                n = cc;
                rend = (ceil_up(scaler_pos.x_pos + pos_t'(cur_scale)) ==
                        ceil_up(pos_t'(eff_width()) * pos_t'(cur_scale)));
                fend = rend && final_pass && last_row;
            end
            moved = next_pos(scaler_pos, tick);
        end
        for (int k = 0; k < n; k++)
        begin
            r = '0;
            r.pixel_valid = valid;
            if (valid)
                {r.out_red, r.out_green, r.out_blue} = px;
            r.last = (k == n - 1);
            r.row_end = rend && (k == n - 1);
            r.frame_end = fend && (k == n - 1);
            r.replay_next = moved.replaying;
            r.sequence_error = err;
            pixel_copies_q.push_back(r);
        end
        scaler_pos = moved;
    endfunction

    function automatic pixel_word_t random_word(logic op);
        pixel_word_t w;
        w.opcode = op;
        w.blue = CHAN_W'($urandom);
        w.green = CHAN_W'($urandom);
        w.red = CHAN_W'($urandom);
        return w;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // valid holds until accepted; pull the next word only when the slot is free
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        if (!rst_n)
        begin
            pixels.valid <= 1'b0;
            pixels.opcode <= OP_PIXEL;
            pixels.blue <= '0;
            pixels.green <= '0;
            pixels.red <= '0;
        end
        else
        begin
            if (pixels.valid && pixels.ready)
                predict_copies(driven_word);
            if (!pixels.valid || pixels.ready)
            begin
                if (source_words_q.size() != 0 && $urandom_range(99) >= sender_idle)
                begin
                    driven_word = source_words_q.pop_front();
                    pixels.valid <= 1'b1;
                    pixels.opcode <= driven_word.opcode;
                    pixels.blue <= driven_word.blue;
                    pixels.green <= driven_word.green;
                    pixels.red <= driven_word.red;
                end
                else
                    pixels.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_results
        pixel_copy_t want;
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            if (results.valid && results.ready)
            begin
                if (pixel_copies_q.size() == 0)
                begin
                    $error("result word with nothing outstanding");
                    error_count++;
                end
                else
                begin
                    want = pixel_copies_q.pop_front();
                    check_field("pixel_valid", want.pixel_valid, results.pixel_valid);
                    check_field("out_blue", want.out_blue, results.out_blue);
                    check_field("out_green", want.out_green, results.out_green);
                    check_field("out_red", want.out_red, results.out_red);
                    check_field("last", want.last, results.last);
                    check_field("row_end", want.row_end, results.row_end);
                    check_field("frame_end", want.frame_end, results.frame_end);
                    check_field("replay_next", want.replay_next, results.replay_next);
                    check_field("sequence_error", want.sequence_error,
                                results.sequence_error);
                end
            end
            results.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic wait_drained();
        while (source_words_q.size() != 0 || pixels.valid || pixel_copies_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SCALE:  cur_scale = data;
            REG_WIDTH:  cur_width = data[DIM_W-1:0];
            REG_HEIGHT: cur_height = data[DIM_W-1:0];
            default:    return;
        endcase
        // any real register write restarts the frame
        scaler_pos = '0;
        plan_pos = '0;
    endtask

    task automatic set_frame(logic [SCALE_W-1:0] scale, logic [SCALE_W-1:0] width,
                             logic [SCALE_W-1:0] height);
        write_reg(REG_SCALE, scale);
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
    endtask

    // well-formed rows and replay passes with a sprinkle of wrong-kind words
    task automatic queue_frame_words(int count);
        pixel_word_t wd;
        int made;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(99) < 8)
                wd = random_word(plan_pos.replaying ? OP_PIXEL : OP_REPLAY);
            else
            begin
                wd = random_word(plan_pos.replaying ? OP_REPLAY : OP_PIXEL);
                plan_pos = next_pos(plan_pos, wd.opcode == OP_REPLAY);
                made++;
            end
            source_words_q.push_back(wd);
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("[nearest_neighbor_pixel_scaler] ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_SCALE;
        cfg_data = '0;
        cur_scale = SCALE_W'(65536);
        cur_width = DIM_W'(1);
        cur_height = DIM_W'(1);
        scaler_pos = '0;
        plan_pos = '0;
        error_count = 0;
        sender_idle = 27;
        recv_idle = 78;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: 1x1 frame at unit scale, then a stray tick
        source_words_q.push_back({OP_PIXEL, 8'h00, 8'h00, 8'h00});
        source_words_q.push_back({OP_PIXEL, 8'hFF, 8'hFF, 8'hFF});
        source_words_q.push_back(random_word(OP_REPLAY));
        wait_drained();

        // 2x upscale of a 2x1 frame: replay pass plus wrong-kind words both ways
        set_frame(SCALE_W'(131072), SCALE_W'(2), SCALE_W'(1));
        source_words_q.push_back(random_word(OP_PIXEL));
        source_words_q.push_back(random_word(OP_REPLAY));
        source_words_q.push_back(random_word(OP_PIXEL));
        source_words_q.push_back(random_word(OP_PIXEL));
        source_words_q.push_back(random_word(OP_REPLAY));
        source_words_q.push_back(random_word(OP_REPLAY));
        wait_drained();

        // half scale: a dropped column and a dropped row
        set_frame(SCALE_W'(32768), SCALE_W'(3), SCALE_W'(2));
        repeat (6) source_words_q.push_back(random_word(OP_PIXEL));
        wait_drained();

        // zero scale drops everything
        write_reg(REG_SCALE, '0);
        source_words_q.push_back(random_word(OP_PIXEL));
        source_words_q.push_back(random_word(OP_REPLAY));
        wait_drained();

        for (int p = 0; p < 12; p++)
        begin
            if (p == 4)
            begin
                sender_idle = 78;
                recv_idle = 27;
            end
            if (p == 8)
            begin
                sender_idle = 0;
                recv_idle = 0;
            end
            case (p)
                0: set_frame(SCALE_W'(98304), SCALE_W'(4), SCALE_W'(3));
                1: set_frame(SCALE_W'(49152), SCALE_W'(6), SCALE_W'(4));
                2: set_frame(SCALE_W'(1), SCALE_W'(3), SCALE_W'(2));
                3: set_frame(SCALE_W'(4194303), SCALE_W'(1), SCALE_W'(1));
                4: write_reg(REG_NONE, SCALE_W'($urandom));
                5: set_frame('0, SCALE_W'(2), SCALE_W'(2));
                7: set_frame(SCALE_W'(196608), '0, '0);
                8: set_frame(SCALE_W'(65536), SCALE_W'(8191), SCALE_W'(8191));
                default: set_frame(SCALE_W'($urandom_range(16384, 262143)),
                                   {9'($urandom), DIM_W'($urandom_range(1, 8))},
                                   {9'($urandom), DIM_W'($urandom_range(1, 5))});
            endcase
            case (p)
                2, 4:    queue_frame_words(16);
                3:       queue_frame_words(40);
                5:       queue_frame_words(10);
                6:
                begin
                    // hold off the sender until the block has fully drained
                    queue_frame_words(14);
                    wait_drained();
                    queue_frame_words(14);
                end
                7:       queue_frame_words(20);
                8:       queue_frame_words(12);
                9, 10, 11: queue_frame_words(20);
                default: queue_frame_words(24);
            endcase
            wait_drained();
        end

        if (error_count == 0)
            $display("[nearest_neighbor_pixel_scaler] OK");
        else
            $display("[nearest_neighbor_pixel_scaler] ERROR");
        $finish;
    end

endmodule
